[design/iidl_pkg.sv]
// Shared types and constants of the indexed insert/delete list.
package iidl_pkg;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and result channels.
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int FPOS_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Operation codes carried by a request.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SET    = 3'd2,
        OP_GET    = 3'd3,
        OP_FIND   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    // Status codes returned with every result.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              apply;
        t_op               op;
        logic [POS_W-1:0]  position;
    } t_cell_ctl;

endpackage

[design/iidl_if.sv]
// Request and result channel interfaces of the indexed insert/delete list.
interface iidl_req_if;
    logic                         valid;
    logic                         ready;
    logic [iidl_pkg::OP_W-1:0]    op;
    logic [iidl_pkg::POS_W-1:0]   position;
    logic [iidl_pkg::WORD_W-1:0]  word;

    modport source (output valid, output op, output position, output word, input ready);
    modport sink   (input valid, input op, input position, input word, output ready);
endinterface

interface iidl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [iidl_pkg::WORD_W-1:0]   read_word;
    logic                          found;
    logic [iidl_pkg::FPOS_W-1:0]   found_position;
    logic [iidl_pkg::COUNT_W-1:0]  count;
    logic                          is_empty;
    logic [iidl_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_word, output found, output found_position,
                    output count, output is_empty, output status, input ready);
    modport sink   (input valid, input read_word, input found, input found_position,
                    input count, input is_empty, input status, output ready);
endinterface

[design/indexed_insert_delete_list.sv]
// Top level of the indexed insert/delete list: sequencer, cell chain and result register.
// The list is a row of CAPACITY cells, one word each, with a fill count. A request is
// accepted when the block is idle and moves it to the execute state; there every cell
// shifts, overwrites or compares at once, the lowest match is picked and the result is
// loaded into the output register, after which the block is idle again. The block takes
// no new request until the result of the last one is loaded; a result left waiting holds
// back the execute step of the following request. Slots need no clearing after reset:
// only slots below the fill count are ever read, and those have all been written.
module indexed_insert_delete_list #(
    parameter int CAPACITY   = iidl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iidl_req_if.sink      i_req,
    iidl_rsp_if.source    o_rsp
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = iidl_pkg::POS_W;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WORD_W   = iidl_pkg::WORD_W;
    localparam int FPOS_W   = iidl_pkg::FPOS_W;
    localparam int COUNT_W  = iidl_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Request, state and count registers.
    iidl_pkg::t_state        r_state;
    iidl_pkg::t_state        n_state;
    logic [iidl_pkg::OP_W-1:0] r_op;
    logic [POS_W-1:0]        r_pos;
    logic [WORD_W-1:0]       r_word;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    // Result register.
    logic                    r_rsp_valid;
    logic [WORD_W-1:0]       r_rsp_read_word;
    logic                    r_rsp_found;
    logic [FPOS_W-1:0]       r_rsp_found_position;
    logic [COUNT_W-1:0]      r_rsp_count;
    logic                    r_rsp_is_empty;
    iidl_pkg::t_status       r_rsp_status;

    logic                    w_accept;
    logic                    w_commit;
    logic                    w_req_ready;
    iidl_pkg::t_status       w_status;
    logic                    w_apply;
    logic                    w_found;
    logic [IDX_W-1:0]        w_found_idx;
    logic [DATA_WIDTH-1:0]   w_read_or;
    logic [WORD_W-1:0]       w_read_word;
    logic [CMP_W-1:0]        w_pos_ext;
    logic [CMP_W-1:0]        w_cnt_ext;
    logic [DATA_WIDTH-1:0]   w_key;
    iidl_pkg::t_cell_ctl     w_ctl;

    logic [DATA_WIDTH-1:0]   w_data  [CAPACITY];
    logic [DATA_WIDTH-1:0]   w_read  [CAPACITY];
    logic [CAPACITY-1:0]     w_match;

    assign w_accept  = i_req.valid && w_req_ready;
    assign w_pos_ext = CMP_W'(r_pos);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_key     = DATA_WIDTH'(r_word);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            iidl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = iidl_pkg::S_EXEC;
                end
            end
            iidl_pkg::S_EXEC: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_state = iidl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iidl_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: request ready and the commit of an executing request.
    always_comb begin
        w_req_ready = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            iidl_pkg::S_IDLE: begin
                w_req_ready = 1'b1;
            end
            iidl_pkg::S_EXEC: begin
                w_commit = !r_rsp_valid || o_rsp.ready;
            end
            default: begin
                w_req_ready = 1'b0;
                w_commit    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iidl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.op;
            r_pos  <= i_req.position;
            r_word <= i_req.word;
        end
    end

    // Range and capacity checks, and the new fill count.
    always_comb begin
        w_status = iidl_pkg::STAT_OK;
        w_apply  = 1'b0;
        n_count  = r_count;
        case (iidl_pkg::t_op'(r_op))
            iidl_pkg::OP_INSERT: begin
                if (w_pos_ext > w_cnt_ext) begin
                    w_status = iidl_pkg::STAT_RANGE;
                end else if (r_count >= CAP_CNT) begin
                    w_status = iidl_pkg::STAT_FULL;
                end else begin
                    w_apply = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            iidl_pkg::OP_REMOVE: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = iidl_pkg::STAT_RANGE;
                end else begin
                    w_apply = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            iidl_pkg::OP_SET: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = iidl_pkg::STAT_RANGE;
                end else begin
                    w_apply = 1'b1;
                end
            end
            iidl_pkg::OP_GET: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = iidl_pkg::STAT_RANGE;
                end
            end
            iidl_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                w_status = iidl_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    // Control broadcast to the cell chain.
    assign w_ctl.apply    = w_commit && w_apply;
    assign w_ctl.op       = iidl_pkg::t_op'(r_op);
    assign w_ctl.position = r_pos;

    // Cell chain: neighbor values, the key below the first, itself above the last.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_key;
        end else begin : g_mid_lo
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_hi
            assign w_right = w_data[g+1];
        end

        iidl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g),
            .CNT_W      (CNT_W),
            .CMP_W      (CMP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_key   (w_key),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g]),
            .o_read  (w_read[g])
        );
    end

    // Lowest matching slot for find.
    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found     = 1'b1;
                w_found_idx = IDX_W'(i);
            end
        end
    end

    // Only the addressed cell drives a nonzero read value.
    always_comb begin
        w_read_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_read_or = w_read_or | w_read[i];
        end
    end

    assign w_read_word = WORD_W'(w_read_or);

    // Result register: loaded on commit, emptied when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_commit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp_status   <= w_status;
            r_rsp_count    <= COUNT_W'(n_count);
            r_rsp_is_empty <= (n_count == '0);
            if (iidl_pkg::t_op'(r_op) == iidl_pkg::OP_GET
                    && w_status == iidl_pkg::STAT_OK) begin
                r_rsp_read_word <= w_read_word;
            end else begin
                r_rsp_read_word <= '0;
            end
            if (iidl_pkg::t_op'(r_op) == iidl_pkg::OP_FIND && w_found) begin
                r_rsp_found          <= 1'b1;
                r_rsp_found_position <= FPOS_W'(w_found_idx);
            end else begin
                r_rsp_found          <= 1'b0;
                r_rsp_found_position <= '0;
            end
        end
    end

    assign i_req.ready          = w_req_ready;
    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.read_word      = r_rsp_read_word;
    assign o_rsp.found          = r_rsp_found;
    assign o_rsp.found_position = r_rsp_found_position;
    assign o_rsp.count          = r_rsp_count;
    assign o_rsp.is_empty       = r_rsp_is_empty;
    assign o_rsp.status         = r_rsp_status;

endmodule

[design/iidl_cell.sv]
// One list slot: holds a word, shifts with its neighbors, compares and reads out.
module iidl_cell #(
    parameter int DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    parameter int CNT_W      = iidl_pkg::COUNT_W,
    parameter int CMP_W      = iidl_pkg::POS_W
) (
    input  logic                   i_clk,
    input  iidl_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [DATA_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_match,
    output logic [DATA_WIDTH-1:0]  o_read
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_cnt;
    logic                  w_at_pos;
    logic                  w_above_pos;

    assign w_pos       = CMP_W'(i_ctl.position);
    assign w_cnt       = CMP_W'(i_count);
    assign w_at_pos    = (MY_IDX == w_pos);
    assign w_above_pos = (MY_IDX > w_pos);

    // Next slot value: take the new word, the lower neighbor or the upper neighbor.
    always_comb begin
        n_data = r_data;
        if (i_ctl.apply) begin
            case (i_ctl.op)
                iidl_pkg::OP_INSERT: begin
                    if (w_at_pos) begin
                        n_data = i_key;
                    end else if (w_above_pos) begin
                        n_data = i_left;
                    end
                end
                iidl_pkg::OP_REMOVE: begin
                    if (w_at_pos || w_above_pos) begin
                        n_data = i_right;
                    end
                end
                iidl_pkg::OP_SET: begin
                    if (w_at_pos) begin
                        n_data = i_key;
                    end
                end
                default: begin
                    n_data = r_data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // A slot only counts as a match while it lies inside the list.
    assign o_match = (r_data == i_key) && (MY_IDX < w_cnt);
    assign o_read  = w_at_pos ? r_data : '0;
    assign o_data  = r_data;

endmodule

[design/iidl_checker.sv]
// Port-level checks of the indexed insert/delete list, bound to the top level.
module iidl_checker #(
    parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [iidl_pkg::WORD_W-1:0]     i_rsp_read_word,
    input logic                            i_rsp_found,
    input logic [iidl_pkg::COUNT_W-1:0]    i_rsp_count,
    input logic                            i_rsp_is_empty,
    input logic [iidl_pkg::STATUS_W-1:0]   i_rsp_status
);

    localparam logic [iidl_pkg::COUNT_W-1:0] CAP_MASKED = iidl_pkg::COUNT_W'(CAPACITY);

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_read_word)
            && $stable(i_rsp_count) && $stable(i_rsp_status))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in work");

    // The empty flag follows the reported count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_is_empty == (i_rsp_count == '0)))
        else $error("empty flag disagrees with count");

    // A full list reports its capacity as the count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == iidl_pkg::STAT_FULL |-> i_rsp_count == CAP_MASKED)
        else $error("full status with a count below capacity");

    // A find hit is a successful request that reads no word.
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_found
            |-> i_rsp_status == iidl_pkg::STAT_OK && i_rsp_read_word == '0)
        else $error("find hit with error status or read data");

endmodule

bind indexed_insert_delete_list iidl_checker #(
    .CAPACITY (CAPACITY)
) u_iidl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_word (o_rsp.read_word),
    .i_rsp_found     (o_rsp.found),
    .i_rsp_count     (o_rsp.count),
    .i_rsp_is_empty  (o_rsp.is_empty),
    .i_rsp_status    (o_rsp.status)
);
